### hdl/ysnd_pkg.sv
// Shared constants, stream packing widths and the CRC-16 byte update for the sender.
package ysnd_pkg;

    localparam int DATA_BLOCK_BYTES   = 1024;
    localparam int HEADER_BLOCK_BYTES = 128;
    localparam int STORE_AW           = $clog2(DATA_BLOCK_BYTES);
    localparam int IDX_W              = 11;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] DATA_LEAD = (DATA_BLOCK_BYTES > 128) ? CH_STX : CH_SOH;

    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_LOAD    = 3'd1;
    localparam logic [2:0] CMD_PEER    = 3'd2;
    localparam logic [2:0] CMD_TIMEOUT = 3'd3;
    localparam logic [2:0] CMD_SLOT    = 3'd4;

    localparam logic [2:0] ST_BUSY  = 3'd0;
    localparam logic [2:0] ST_OK    = 3'd1;
    localparam logic [2:0] ST_FSYNC = 3'd2;
    localparam logic [2:0] ST_FHDR  = 3'd3;
    localparam logic [2:0] ST_FFILE = 3'd4;
    localparam logic [2:0] ST_FTAIL = 3'd5;

    localparam logic [0:0] REG_SYNC_ATTEMPTS   = 1'b0;
    localparam logic [0:0] REG_HEADER_ATTEMPTS = 1'b1;

    typedef struct packed {
        logic [31:0] bytes_done;
        logic [2:0]  status;
        logic        want_payload;
        logic [7:0]  tx_byte;
        logic        tx_valid;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hdl/ysnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ysnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/ymodem_file_sender.sv
// Block sender engine: one byte event per transfer, framing, CRC-16 and handshake control.
// One input transfer is taken every cycle while the result register is free or being
// drained; each transfer yields exactly one result, presented in the following cycle.
// All phase, framing and CRC work for an event is done combinationally as it is taken.
// The packet store is a 1024-byte RAM whose read address tracks the next payload
// position, so payload bytes are ready for back-to-back transmit slots. No clearing pass:
// the host loads each header and data block before sending; the tail header is zeros.
module ymodem_file_sender
    import ysnd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], file_size[39:8]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // tx_valid[0], tx_byte[8:1], want_payload[9],
                                   // status[12:10], bytes_done[44:13], zero[47:45]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_SYNC  = 5'd1;
    localparam logic [4:0] PH_HLOAD = 5'd2;
    localparam logic [4:0] PH_HSEND = 5'd3;
    localparam logic [4:0] PH_HACK  = 5'd4;
    localparam logic [4:0] PH_HC    = 5'd5;
    localparam logic [4:0] PH_DLOAD = 5'd6;
    localparam logic [4:0] PH_DSEND = 5'd7;
    localparam logic [4:0] PH_DACK  = 5'd8;
    localparam logic [4:0] PH_ESEND = 5'd9;
    localparam logic [4:0] PH_EACK  = 5'd10;
    localparam logic [4:0] PH_EC    = 5'd11;
    localparam logic [4:0] PH_TSEND = 5'd12;
    localparam logic [4:0] PH_TACK  = 5'd13;
    localparam logic [4:0] PH_TC    = 5'd14;
    localparam logic [4:0] PH_OK    = 5'd15;
    localparam logic [4:0] PH_FSYNC = 5'd16;
    localparam logic [4:0] PH_FHDR  = 5'd17;
    localparam logic [4:0] PH_FFILE = 5'd18;
    localparam logic [4:0] PH_FTAIL = 5'd19;

    localparam logic [IDX_W-1:0] HDR_SIZE  = IDX_W'(HEADER_BLOCK_BYTES);
    localparam logic [IDX_W-1:0] DATA_SIZE = IDX_W'(DATA_BLOCK_BYTES);

    logic [6:0]       sync_att_reg, hdr_att_reg;
    logic [4:0]       phase_reg, phase_next;
    logic [6:0]       att_reg, att_next;
    logic [7:0]       blk_reg, blk_next;
    logic [31:0]      acked_reg, acked_next;
    logic [31:0]      total_reg, total_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic             ack_reg, ack_next;
    logic             m_tvalid_reg;
    result_t          res_reg, res_next;

    logic             accept;
    logic [2:0]       cmd;
    logic [7:0]       din;
    logic [31:0]      fsize;
    logic             got;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic [IDX_W-1:0] ridx;
    logic [IDX_W-1:0] fsz;
    logic [7:0]       flead, fnum, fv;
    logic             fzero, fdone, is_send;
    logic [31:0]      left;
    logic [6:0]       hdr_load, sync_load;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser;
    assign din      = s_tdata[7:0];
    assign fsize    = s_tdata[39:8];
    assign got      = (cmd == CMD_PEER);
    assign hdr_load  = (hdr_att_reg == 7'd0) ? 7'd1 : hdr_att_reg;
    assign sync_load = (sync_att_reg == 7'd0) ? 7'd1 : sync_att_reg;
    assign left     = total_reg - acked_reg;

    always_comb begin
        is_send = 1'b1;
        flead   = CH_SOH;
        fnum    = 8'd0;
        fsz     = HDR_SIZE;
        fzero   = 1'b0;
        unique case (phase_reg)
            PH_HSEND: ;
            PH_DSEND: begin
                flead = DATA_LEAD;
                fnum  = blk_reg;
                fsz   = DATA_SIZE;
            end
            PH_TSEND: fzero = 1'b1;
            default: is_send = 1'b0;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        att_next   = att_reg;
        blk_next   = blk_reg;
        acked_next = acked_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        ack_next   = ack_reg;
        ram_we     = 1'b0;
        fdone      = 1'b0;
        fv         = 8'd0;
        res_next   = res_reg;
        if (accept) begin
            res_next.tx_valid = 1'b0;
            res_next.tx_byte  = 8'd0;
            unique case (cmd)
                CMD_START: begin
                    total_next = fsize;
                    acked_next = 32'd0;
                    blk_next   = 8'd0;
                    idx_next   = '0;
                    crc_next   = 16'd0;
                    ack_next   = 1'b0;
                    att_next   = sync_load;
                    phase_next = PH_SYNC;
                end
                CMD_LOAD: begin
                    if (phase_reg == PH_HLOAD || phase_reg == PH_DLOAD) begin
                        ram_we = 1'b1;
                        if (idx_reg + 1'b1 >= ((phase_reg == PH_HLOAD) ? HDR_SIZE : DATA_SIZE))
                        begin
                            idx_next   = '0;
                            phase_next = phase_reg + 5'd1;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
                CMD_PEER, CMD_TIMEOUT: begin
                    unique case (phase_reg)
                        PH_SYNC: begin
                            if (got && din == CH_C) begin
                                phase_next = PH_HLOAD;
                                idx_next   = '0;
                                att_next   = hdr_load;
                            end else if (att_reg <= 7'd1) begin
                                att_next   = 7'd0;
                                phase_next = PH_FSYNC;
                            end else begin
                                att_next = att_reg - 7'd1;
                            end
                        end
                        PH_HACK, PH_TACK: begin
                            ack_next   = got && din == CH_ACK;
                            phase_next = phase_reg + 5'd1;
                        end
                        PH_HC, PH_TC: begin
                            if (ack_reg && got && din == CH_C) begin
                                if (phase_reg == PH_TC) begin
                                    phase_next = PH_OK;
                                end else if (total_reg == 32'd0) begin
                                    phase_next = PH_FFILE;
                                end else begin
                                    phase_next = PH_DLOAD;
                                    blk_next   = 8'd1;
                                    idx_next   = '0;
                                end
                            end else if (att_reg <= 7'd1) begin
                                att_next   = 7'd0;
                                phase_next = (phase_reg == PH_TC) ? PH_FTAIL : PH_FHDR;
                            end else begin
                                att_next   = att_reg - 7'd1;
                                idx_next   = '0;
                                phase_next = phase_reg - 5'd2;
                            end
                        end
                        PH_DACK: begin
                            if (got && din == CH_ACK) begin
                                blk_next = blk_reg + 8'd1;
                                idx_next = '0;
                                if (left <= 32'(DATA_BLOCK_BYTES)) begin
                                    acked_next = total_reg;
                                    phase_next = PH_ESEND;
                                end else begin
                                    acked_next = acked_reg + 32'(DATA_BLOCK_BYTES);
                                    phase_next = PH_DLOAD;
                                end
                            end else if (!got || din == CH_CAN) begin
                                phase_next = PH_FFILE;
                            end else begin
                                idx_next   = '0;
                                phase_next = PH_DSEND;
                            end
                        end
                        PH_EACK: begin
                            if (got && din == CH_ACK) begin
                                phase_next = PH_EC;
                            end else if (!got) begin
                                phase_next = PH_FFILE;
                            end else begin
                                phase_next = PH_ESEND;
                            end
                        end
                        PH_EC: begin
                            if (got && din == CH_C) begin
                                phase_next = PH_TSEND;
                                idx_next   = '0;
                                att_next   = hdr_load;
                            end else begin
                                phase_next = PH_FFILE;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_SLOT: begin
                    if (is_send) begin
                        priority if (idx_reg == '0) begin
                            crc_next = 16'd0;
                            fv       = flead;
                        end else if (idx_reg == IDX_W'(1)) begin
                            fv = fnum;
                        end else if (idx_reg == IDX_W'(2)) begin
                            fv = ~fnum;
                        end else if (idx_reg < fsz + IDX_W'(3)) begin
                            fv       = fzero ? 8'd0 : ram_rdata;
                            crc_next = crc16_byte(crc_reg, fv);
                        end else if (idx_reg == fsz + IDX_W'(3)) begin
                            fv = crc_reg[15:8];
                        end else begin
                            fv    = crc_reg[7:0];
                            fdone = 1'b1;
                        end
                        idx_next          = fdone ? '0 : idx_reg + 1'b1;
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = fv;
                        if (fdone) begin
                            phase_next = phase_reg + 5'd1;
                        end
                    end else if (phase_reg == PH_ESEND) begin
                        res_next.tx_valid = 1'b1;
                        res_next.tx_byte  = CH_EOT;
                        phase_next        = PH_EACK;
                    end
                end
                default: ;
            endcase
            res_next.want_payload = (phase_next == PH_HLOAD || phase_next == PH_DLOAD);
            unique case (phase_next)
                PH_OK:    res_next.status = ST_OK;
                PH_FSYNC: res_next.status = ST_FSYNC;
                PH_FHDR:  res_next.status = ST_FHDR;
                PH_FFILE: res_next.status = ST_FFILE;
                PH_FTAIL: res_next.status = ST_FTAIL;
                default:  res_next.status = ST_BUSY;
            endcase
            res_next.bytes_done = acked_next;
        end
    end

    assign ridx = idx_next - IDX_W'(3);

    ysnd_ram #(
        .WIDTH(8),
        .DEPTH(DATA_BLOCK_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[STORE_AW-1:0]),
        .wdata (din),
        .raddr (ridx[STORE_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            att_reg      <= 7'd0;
            blk_reg      <= 8'd0;
            acked_reg    <= 32'd0;
            total_reg    <= 32'd0;
            idx_reg      <= '0;
            crc_reg      <= 16'd0;
            ack_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            att_reg   <= att_next;
            blk_reg   <= blk_next;
            acked_reg <= acked_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            ack_reg   <= ack_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_att_reg <= 7'd100;
            hdr_att_reg  <= 7'd99;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_SYNC_ATTEMPTS:   sync_att_reg <= pwdata[6:0];
                REG_HEADER_ATTEMPTS: hdr_att_reg  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_HEADER_ATTEMPTS) ? {25'd0, hdr_att_reg}
                                                        : {25'd0, sync_att_reg};
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, res_reg};

`ifndef SYNTH
    a_acked_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acked_reg <= total_reg)
        else $error("acknowledged count passed file size");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= DATA_SIZE + IDX_W'(4))
        else $error("frame index out of range");

    a_final_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12:10] != ST_BUSY) |-> !m_tdata[0])
        else $error("byte sent with a final status");
`endif

endmodule

### verif/ymodem_file_sender_tb.sv
// Self-checking testbench for the block sender: directed table, random transfers, scoreboard.
`timescale 1ns / 100ps
module ymodem_file_sender_tb;
    import ysnd_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SESSION_CAP    = 5000;
    localparam int          STAGE_ITEMS    = 275;
    localparam logic [7:0]  CH_NAK         = 8'h15;
    localparam logic [2:0]  CMD_RSVD_HI    = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_SYNC, S_HLOAD, S_HSEND, S_HACK, S_HC, S_DLOAD, S_DSEND, S_DACK,
        S_ESEND, S_EACK, S_EC, S_TSEND, S_TACK, S_TC, S_OK, S_FSYNC, S_FHDR,
        S_FFILE, S_FTAIL
    } xfer_phase_e;

    typedef enum int {HS_WAIT, HS_PASS, HS_FAIL} handshake_e;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  data_byte;
        logic [31:0] file_size;
        bit          typed;
        logic [2:0]  status;
        logic        want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // data_byte[7:0], file_size[39:8]
    logic [2:0]  s_tuser;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // tx_valid[0], tx_byte[8:1], want_payload[9], status[12:10],
                            // bytes_done[44:13], zero[47:45]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ymodem_file_sender DUT (.*);

    // sender-side model state
    xfer_phase_e ph = S_IDLE;
    logic [6:0]  tries = '0;
    logic [7:0]  blk_num = '0;
    logic [31:0] acked = '0;
    logic [31:0] total = '0;
    logic [7:0]  pkt_store [DATA_BLOCK_BYTES];
    int unsigned pos = 0;
    logic [15:0] crc_acc = '0;
    bit          ack_got = 1'b0;
    logic [6:0]  cfg_sync = 7'd100;
    logic [6:0]  cfg_hdr = 7'd99;

    result_t     expected_q [$];
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_errors = 0;
    int          n_ok_files = 0;
    int          n_sessions = 0;
    int          quiet = 0;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [6:0] one_at_least(input logic [6:0] r);
        return (r == 0) ? 7'd1 : r;
    endfunction

    function automatic logic [7:0] frame_next(input logic [7:0] lead, input logic [7:0] num,
                                              input int unsigned size, input bit zeros,
                                              output bit done);
        int unsigned p;
        int unsigned k;
        logic [7:0]  v;
        p = pos;
        done = 1'b0;
        if (p == 0) begin
            crc_acc = '0;
            v = lead;
        end else if (p == 1) begin
            v = num;
        end else if (p == 2) begin
            v = ~num;
        end else if (p < size + 3) begin
            k = p - 3;
            v = (zeros || k >= DATA_BLOCK_BYTES) ? 8'h00 : pkt_store[k];
            crc_acc = crc_step(crc_acc, v);
        end else if (p == size + 3) begin
            v = crc_acc[15:8];
        end else begin
            v = crc_acc[7:0];
            done = 1'b1;
        end
        pos = done ? 0 : p + 1;
        return v;
    endfunction

    function automatic handshake_e block0_reply(input bit got, input logic [7:0] b,
                                                input xfer_phase_e ack_ph,
                                                input xfer_phase_e c_ph,
                                                input xfer_phase_e send_ph);
        if (ph == ack_ph) begin
            ack_got = got && b == CH_ACK;
            ph = c_ph;
            return HS_WAIT;
        end
        if (ack_got && got && b == CH_C) return HS_PASS;
        if (tries <= 1) begin
            tries = '0;
            return HS_FAIL;
        end
        tries = tries - 7'd1;
        pos = 0;
        ph = send_ph;
        return HS_WAIT;
    endfunction

    function automatic void peer_event(input bit got, input logic [7:0] b);
        handshake_e  r;
        logic [31:0] left;
        case (ph)
            S_SYNC: begin
                if (got && b == CH_C) begin
                    ph = S_HLOAD;
                    pos = 0;
                    tries = one_at_least(cfg_hdr);
                end else if (tries <= 1) begin
                    tries = '0;
                    ph = S_FSYNC;
                end else begin
                    tries = tries - 7'd1;
                end
            end
            S_HACK, S_HC: begin
                r = block0_reply(got, b, S_HACK, S_HC, S_HSEND);
                if (r == HS_PASS) begin
                    if (total == 0) begin
                        ph = S_FFILE;
                    end else begin
                        ph = S_DLOAD;
                        blk_num = 8'd1;
                        pos = 0;
                    end
                end else if (r == HS_FAIL) begin
                    ph = S_FHDR;
                end
            end
            S_DACK: begin
                if (got && b == CH_ACK) begin
                    left = total - acked;
                    acked = acked + ((left < DATA_BLOCK_BYTES) ? left : DATA_BLOCK_BYTES);
                    blk_num = blk_num + 8'd1;
                    pos = 0;
                    ph = (acked >= total) ? S_ESEND : S_DLOAD;
                end else if (!got || b == CH_CAN) begin
                    ph = S_FFILE;
                end else begin
                    pos = 0;
                    ph = S_DSEND;
                end
            end
            S_EACK: begin
                if (got && b == CH_ACK) ph = S_EC;
                else if (!got) ph = S_FFILE;
                else ph = S_ESEND;
            end
            S_EC: begin
                if (got && b == CH_C) begin
                    ph = S_TSEND;
                    pos = 0;
                    tries = one_at_least(cfg_hdr);
                end else begin
                    ph = S_FFILE;
                end
            end
            S_TACK, S_TC: begin
                r = block0_reply(got, b, S_TACK, S_TC, S_TSEND);
                if (r == HS_PASS) ph = S_OK;
                else if (r == HS_FAIL) ph = S_FTAIL;
            end
            default: ;
        endcase
    endfunction

    function automatic result_t predict_result(input logic [2:0] cmd, input logic [7:0] b,
                                               input logic [31:0] fs);
        result_t     r;
        bit          done;
        int unsigned size;
        r = '0;
        done = 1'b0;
        case (cmd)
            CMD_START: begin
                total = fs;
                acked = '0;
                blk_num = '0;
                pos = 0;
                crc_acc = '0;
                ack_got = 1'b0;
                tries = one_at_least(cfg_sync);
                ph = S_SYNC;
            end
            CMD_LOAD: begin
                if (ph == S_HLOAD || ph == S_DLOAD) begin
                    size = (ph == S_HLOAD) ? HEADER_BLOCK_BYTES : DATA_BLOCK_BYTES;
                    if (pos < DATA_BLOCK_BYTES) pkt_store[pos] = b;
                    pos = pos + 1;
                    if (pos >= size) begin
                        pos = 0;
                        ph = (ph == S_HLOAD) ? S_HSEND : S_DSEND;
                    end
                end
            end
            CMD_PEER, CMD_TIMEOUT: peer_event(cmd == CMD_PEER, b);
            CMD_SLOT: begin
                if (ph == S_HSEND) begin
                    r.tx_byte = frame_next(CH_SOH, 8'h00, HEADER_BLOCK_BYTES, 1'b0, done);
                    r.tx_valid = 1'b1;
                    if (done) ph = S_HACK;
                end else if (ph == S_DSEND) begin
                    r.tx_byte = frame_next(DATA_LEAD, blk_num, DATA_BLOCK_BYTES, 1'b0, done);
                    r.tx_valid = 1'b1;
                    if (done) ph = S_DACK;
                end else if (ph == S_TSEND) begin
                    r.tx_byte = frame_next(CH_SOH, 8'h00, HEADER_BLOCK_BYTES, 1'b1, done);
                    r.tx_valid = 1'b1;
                    if (done) ph = S_TACK;
                end else if (ph == S_ESEND) begin
                    r.tx_byte = CH_EOT;
                    r.tx_valid = 1'b1;
                    ph = S_EACK;
                end
            end
            default: ;
        endcase
        case (ph)
            S_OK:    r.status = ST_OK;
            S_FSYNC: r.status = ST_FSYNC;
            S_FHDR:  r.status = ST_FHDR;
            S_FFILE: r.status = ST_FFILE;
            S_FTAIL: r.status = ST_FTAIL;
            default: r.status = ST_BUSY;
        endcase
        r.want_payload = (ph == S_HLOAD || ph == S_DLOAD);
        r.bytes_done = acked;
        return r;
    endfunction

    task automatic send_event(input logic [2:0] cmd, input logic [7:0] b,
                              input logic [31:0] fs, input bit typed = 1'b0,
                              input result_t typed_exp = '0);
        result_t p;
        @(negedge aclk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {fs, b};
        do @(posedge aclk); while (!s_tready);
        p = predict_result(cmd, b, fs);
        expected_q.push_back(typed ? typed_exp : p);
        n_items++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [6:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_SYNC_ATTEMPTS) cfg_sync = value;
        else cfg_hdr = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_attempts(input logic [6:0] sync_v, input logic [6:0] hdr_v);
        drain_results();
        apb_write(REG_SYNC_ATTEMPTS, sync_v);
        apb_write(REG_HEADER_ATTEMPTS, hdr_v);
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 32'd0;
        if (r < 80) return $urandom_range(1, DATA_BLOCK_BYTES);
        if (r < 90) return $urandom_range(DATA_BLOCK_BYTES + 1, 2 * DATA_BLOCK_BYTES);
        return $urandom;
    endfunction

    // Drive one transfer from start to its end or step budget, as a mostly well-behaved peer.
    task automatic run_file(input logic [31:0] fs, input int noise_pct, input int max_steps);
        int steps;
        int r;
        steps = 0;
        send_event(CMD_START, 8'($urandom), fs);
        while (!(ph inside {S_IDLE, S_OK, S_FSYNC, S_FHDR, S_FFILE, S_FTAIL})
               && steps < max_steps) begin
            steps++;
            r = $urandom_range(99);
            if ($urandom_range(99) < noise_pct) begin
                send_event(3'($urandom_range(CMD_LOAD, CMD_RSVD_HI)), 8'($urandom), $urandom);
            end else begin
                case (ph)
                    S_SYNC: begin
                        if (r < 85) send_event(CMD_PEER, CH_C, '0);
                        else if (r < 93) send_event(CMD_PEER, 8'($urandom), '0);
                        else send_event(CMD_TIMEOUT, 8'($urandom), '0);
                    end
                    S_HLOAD, S_DLOAD: send_event(CMD_LOAD, 8'($urandom), $urandom);
                    S_HACK, S_TACK: begin
                        if (r < 88) send_event(CMD_PEER, CH_ACK, '0);
                        else if (r < 94) send_event(CMD_PEER, CH_NAK, '0);
                        else send_event(CMD_TIMEOUT, CH_ACK, '0);
                    end
                    S_HC, S_TC, S_EC: begin
                        if (r < 93) send_event(CMD_PEER, CH_C, '0);
                        else send_event(CMD_PEER, 8'($urandom), '0);
                    end
                    S_DACK: begin
                        if (r < 88) send_event(CMD_PEER, CH_ACK, '0);
                        else if (r < 95) send_event(CMD_PEER, CH_NAK, '0);
                        else if (r < 97) send_event(CMD_PEER, CH_CAN, '0);
                        else send_event(CMD_TIMEOUT, 8'($urandom), '0);
                    end
                    S_EACK: begin
                        if (r < 85) send_event(CMD_PEER, CH_ACK, '0);
                        else if (r < 97) send_event(CMD_PEER, CH_NAK, '0);
                        else send_event(CMD_TIMEOUT, 8'($urandom), '0);
                    end
                    default: send_event(CMD_SLOT, 8'($urandom), $urandom);
                endcase
            end
        end
        if (ph == S_OK) n_ok_files++;
        n_sessions++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
        if (want !== got) begin
            bad = 1'b1;
            if (n_errors < 10) begin
                $display("mismatch on result %0d: %s expected %0h got %0h",
                         n_results, name, want, got);
            end
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        bit      bad;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[44:0]);
            bad = 1'b0;
            if (expected_q.size() == 0) begin
                if (n_errors < 10) $display("unexpected result transfer %0h", m_tdata);
                n_errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("tx_valid", want.tx_valid, got.tx_valid, bad);
                check_field("tx_byte", want.tx_byte, got.tx_byte, bad);
                check_field("want_payload", want.want_payload, got.want_payload, bad);
                check_field("status", want.status, got.status, bad);
                check_field("bytes_done", want.bytes_done, got.bytes_done, bad);
                check_field("pad", 32'd0, {29'd0, m_tdata[47:45]}, bad);
                if (bad) n_errors++;
            end
            n_results++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t rows [$];
        result_t   te;
        rows = '{
            '{CMD_SLOT,    8'h00, 32'h0000_0000, 1'b1, ST_BUSY,  1'b0},
            '{CMD_RSVD_HI, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_BUSY,  1'b0},
            '{CMD_LOAD,    8'hFF, 32'h0000_0000, 1'b1, ST_BUSY,  1'b0},
            '{CMD_PEER,    CH_C,  32'h0000_0000, 1'b1, ST_BUSY,  1'b0},
            '{CMD_TIMEOUT, 8'h00, 32'h0000_0000, 1'b1, ST_BUSY,  1'b0},
            '{CMD_START,   8'h00, 32'hFFFF_FFFF, 1'b1, ST_BUSY,  1'b0},
            '{CMD_TIMEOUT, 8'h00, 32'h0000_0000, 1'b1, ST_FSYNC, 1'b0},
            '{CMD_SLOT,    8'h00, 32'h0000_0000, 1'b1, ST_FSYNC, 1'b0},
            '{CMD_PEER,    CH_C,  32'h0000_0000, 1'b1, ST_FSYNC, 1'b0},
            '{CMD_START,   8'hFF, 32'h0000_0000, 1'b1, ST_BUSY,  1'b0},
            '{CMD_PEER,    CH_C,  32'h0000_0000, 1'b1, ST_BUSY,  1'b1},
            '{CMD_PEER,    CH_NAK, 32'h0000_0000, 1'b0, ST_BUSY, 1'b0}
        };
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apb_write(REG_SYNC_ATTEMPTS, 7'd0);
        apb_write(REG_HEADER_ATTEMPTS, 7'd0);
        foreach (rows[i]) begin
            te = '0;
            te.status = rows[i].status;
            te.want_payload = rows[i].want;
            send_event(rows[i].cmd, rows[i].data_byte, rows[i].file_size, rows[i].typed, te);
        end
        // header with a single attempt: a timeout then a stray byte fails it
        while (ph == S_HLOAD) send_event(CMD_LOAD, 8'($urandom), '0);
        while (ph == S_HSEND) send_event(CMD_SLOT, '0, '0);
        send_event(CMD_TIMEOUT, '0, '0);
        send_event(CMD_PEER, CH_NAK, '0);
        run_file(32'd0, 0, SESSION_CAP);

        for (int stage = 0; stage < 4; stage++) begin
            int stage_start;
            case (stage)
                0: begin set_attempts(7'd127, 7'd127); idle_pct = 0;  stall_pct = 0;  end
                1: begin set_attempts(7'd2, 7'd1);     idle_pct = 46; stall_pct = 0;  end
                2: begin set_attempts(7'd100, 7'd99);  idle_pct = 0;  stall_pct = 46; end
                default: begin set_attempts(7'd5, 7'd3); idle_pct = 8; stall_pct = 8; end
            endcase
            stage_start = n_items;
            if (stage == 0) begin
                run_file($urandom_range(1, DATA_BLOCK_BYTES), 0, STAGE_ITEMS - 1);
            end
            while (n_items - stage_start < STAGE_ITEMS) begin
                run_file(pick_size(), 4, STAGE_ITEMS - (n_items - stage_start) - 1);
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        $display("covered %0d input transfers, %0d results, %0d file sessions",
                 n_items, n_results, n_sessions);
        $display("%0d sessions finished cleanly, %0d mismatches", n_ok_files, n_errors);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
